FILE: hdl/lexeme_class_dfa_unit_defines.svh
// Assertion macros for the lexeme classifier.
// Included by the top level; no other dependencies.
`ifndef LEXEME_CLASS_DFA_UNIT_DEFINES_SVH
`define LEXEME_CLASS_DFA_UNIT_DEFINES_SVH

// Checked only while out of reset
`define LCD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked at every edge, reset included
`define LCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/lcd_pkg.sv
// Shared types and constants of the lexeme classifier.
// No dependencies.
`timescale 1ns / 1ps

package lcd_pkg;

    typedef logic [7:0] t_char;
    typedef logic [4:0] t_state;
    typedef logic [3:0] t_class;
    typedef logic [3:0] t_len;

    // Scanner states
    localparam t_state ST_START    = 5'd0;
    localparam t_state ST_IDENT    = 5'd1;
    localparam t_state ST_KEYWORD  = 5'd2;
    localparam t_state ST_SIGN     = 5'd3;
    localparam t_state ST_INT      = 5'd4;
    localparam t_state ST_DOT      = 5'd5;
    localparam t_state ST_DEC      = 5'd6;
    localparam t_state ST_EXP      = 5'd7;
    localparam t_state ST_EXP_SIGN = 5'd8;
    localparam t_state ST_EXP_DIG  = 5'd9;
    localparam t_state ST_ANDOR    = 5'd10;
    localparam t_state ST_BANG     = 5'd11;
    localparam t_state ST_LOGIC2   = 5'd12;
    localparam t_state ST_RELOP    = 5'd13;
    localparam t_state ST_EQ       = 5'd14;
    localparam t_state ST_RELEQ    = 5'd15;
    localparam t_state ST_ARITH    = 5'd16;
    localparam t_state ST_DEAD     = 5'd17;

    // Token classes
    localparam t_class CLS_INVALID    = 4'd0;
    localparam t_class CLS_IDENT      = 4'd1;
    localparam t_class CLS_KEYWORD    = 4'd2;
    localparam t_class CLS_INTEGER    = 4'd3;
    localparam t_class CLS_DECIMAL    = 4'd4;
    localparam t_class CLS_EXPONENT   = 4'd5;
    localparam t_class CLS_LOGICAL    = 4'd6;
    localparam t_class CLS_RELATIONAL = 4'd7;
    localparam t_class CLS_ARITH      = 4'd8;

    // Characters tested one by one
    localparam t_char CH_PLUS  = 8'h2B;
    localparam t_char CH_MINUS = 8'h2D;
    localparam t_char CH_AND   = 8'h26;
    localparam t_char CH_OR    = 8'h7C;
    localparam t_char CH_BANG  = 8'h21;
    localparam t_char CH_GT    = 8'h3E;
    localparam t_char CH_LT    = 8'h3C;
    localparam t_char CH_EQ    = 8'h3D;
    localparam t_char CH_STAR  = 8'h2A;
    localparam t_char CH_SLASH = 8'h2F;
    localparam t_char CH_DOT   = 8'h2E;
    localparam t_char CH_UPR_E = 8'h45;

    localparam int NUM_KW = 8;

    // Keyword text, first character in the low byte, zero padded
    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        64'h0000_0000_0000_6669,   // if
        64'h0000_0000_6573_6c65,   // else
        64'h0000_0065_6c69_6877,   // while
        64'h0000_6e72_7574_6572,   // return
        64'h0000_0000_0072_6f66,   // for
        64'h0000_0000_0074_6e69,   // int
        64'h0000_0074_616f_6c66,   // float
        64'h0000_0000_6469_6f76    // void
    };

    localparam t_len KW_LEN [NUM_KW] = '{
        4'd2, 4'd4, 4'd5, 4'd6, 4'd3, 4'd3, 4'd5, 4'd4
    };

    // Front to queue: one finished classification
    typedef struct packed {
        logic   valid;
        t_class token_class;
    } t_push;

endpackage

FILE: hdl/lcd_if.sv
// Stream interfaces of the lexeme classifier: character in, class out.
// Depends on lcd_pkg.
`timescale 1ns / 1ps

interface lcd_char_if;
    logic           valid;
    logic           ready;
    lcd_pkg::t_char ch;
    logic           last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface lcd_class_if;
    logic            valid;
    logic            ready;
    lcd_pkg::t_class token_class;

    modport source (output valid, output token_class, input ready);
    modport sink   (input valid, input token_class, output ready);
endinterface

FILE: hdl/lexeme_class_dfa_unit.sv
// Top level of the lexeme classifier: scanner front end feeding a result queue.
// Depends on lcd_pkg, lcd_if, lcd_front, lcd_queue and the assertion header.
//
//  Port      Dir  Payload              Transaction
//  i_char    in   ch[7:0], last        one character of a lexeme
//  o_class   out  token_class[3:0]     class of a finished lexeme
//
// One character per cycle while i_char.ready is high; the scanner takes a DFA step and a keyword compare
// in the cycle a character is accepted.
// A class appears on o_class in the cycle after the last character is accepted,
// later only while classes queued ahead of it wait for o_class.ready.
// i_rst_n is synchronous: scanner returns to start, queue empties.
// i_char.ready drops only while all QUEUE_DEPTH queue entries hold classes.
`timescale 1ns / 1ps
`include "lexeme_class_dfa_unit_defines.svh"

module lexeme_class_dfa_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcd_char_if.sink    i_char,
    lcd_class_if.source o_class
);

    lcd_pkg::t_push w_push;
    logic           w_room;
    logic           w_cls_ok;

    lcd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_room  (w_room),
        .o_push  (w_push)
    );

    lcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_class (o_class)
    );

    assign w_cls_ok = o_class.token_class <= lcd_pkg::CLS_ARITH;

    `LCD_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_class.valid, "valid after reset")
    `LCD_ASSERT(a_push_shows, i_clk, i_rst_n, w_push.valid |=> o_class.valid, "class not shown")
    `LCD_ASSERT(a_cls_range, i_clk, i_rst_n, o_class.valid |-> w_cls_ok, "class out of range")

endmodule

FILE: hdl/lcd_front.sv
// Front end: scanner DFA and keyword comparators, one character per cycle while the queue has room.
// Depends on lcd_pkg and lcd_char_if.
`timescale 1ns / 1ps

module lcd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lcd_char_if.sink          i_char,
    input  logic              i_room,
    output lcd_pkg::t_push    o_push
);

    function automatic lcd_pkg::t_state f_next(input lcd_pkg::t_state s,
                                               input lcd_pkg::t_char c);
        logic is_let;
        logic is_dig;
        logic is_sgn;
        logic is_ao;
        is_let = c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
        is_dig = c inside {[8'h30:8'h39]};
        is_sgn = (c == lcd_pkg::CH_PLUS) || (c == lcd_pkg::CH_MINUS);
        is_ao  = (c == lcd_pkg::CH_AND) || (c == lcd_pkg::CH_OR);
        f_next = lcd_pkg::ST_DEAD;
        case (s)
            lcd_pkg::ST_START: begin
                if (is_let)                     f_next = lcd_pkg::ST_IDENT;
                else if (is_sgn)                f_next = lcd_pkg::ST_SIGN;
                else if (is_dig)                f_next = lcd_pkg::ST_INT;
                else if (is_ao)                 f_next = lcd_pkg::ST_ANDOR;
                else if (c == lcd_pkg::CH_BANG) f_next = lcd_pkg::ST_BANG;
                else if (c == lcd_pkg::CH_GT || c == lcd_pkg::CH_LT)
                    f_next = lcd_pkg::ST_RELOP;
                else if (c == lcd_pkg::CH_EQ)   f_next = lcd_pkg::ST_EQ;
                else if (c == lcd_pkg::CH_STAR || c == lcd_pkg::CH_SLASH)
                    f_next = lcd_pkg::ST_ARITH;
            end
            lcd_pkg::ST_IDENT: begin
                if (is_let || is_dig) f_next = lcd_pkg::ST_IDENT;
            end
            lcd_pkg::ST_SIGN: begin
                if (is_dig) f_next = lcd_pkg::ST_INT;
            end
            lcd_pkg::ST_INT: begin
                if (is_dig)                    f_next = lcd_pkg::ST_INT;
                else if (c == lcd_pkg::CH_DOT) f_next = lcd_pkg::ST_DOT;
            end
            lcd_pkg::ST_DOT: begin
                if (is_dig) f_next = lcd_pkg::ST_DEC;
            end
            lcd_pkg::ST_DEC: begin
                if (is_dig)                      f_next = lcd_pkg::ST_DEC;
                else if (c == lcd_pkg::CH_UPR_E) f_next = lcd_pkg::ST_EXP;
            end
            lcd_pkg::ST_EXP: begin
                if (is_sgn) f_next = lcd_pkg::ST_EXP_SIGN;
            end
            lcd_pkg::ST_EXP_SIGN, lcd_pkg::ST_EXP_DIG: begin
                if (is_dig) f_next = lcd_pkg::ST_EXP_DIG;
            end
            lcd_pkg::ST_ANDOR: begin
                if (is_ao) f_next = lcd_pkg::ST_LOGIC2;
            end
            lcd_pkg::ST_BANG, lcd_pkg::ST_RELOP, lcd_pkg::ST_EQ: begin
                if (c == lcd_pkg::CH_EQ) f_next = lcd_pkg::ST_RELEQ;
            end
            default: f_next = lcd_pkg::ST_DEAD;
        endcase
    endfunction

    function automatic lcd_pkg::t_class f_class(input lcd_pkg::t_state s,
                                                input logic kw);
        case (s)
            lcd_pkg::ST_IDENT:     f_class = kw ? lcd_pkg::CLS_KEYWORD : lcd_pkg::CLS_IDENT;
            lcd_pkg::ST_KEYWORD:   f_class = lcd_pkg::CLS_KEYWORD;
            lcd_pkg::ST_INT:       f_class = lcd_pkg::CLS_INTEGER;
            lcd_pkg::ST_DEC:       f_class = lcd_pkg::CLS_DECIMAL;
            lcd_pkg::ST_EXP_DIG:   f_class = lcd_pkg::CLS_EXPONENT;
            lcd_pkg::ST_BANG,
            lcd_pkg::ST_LOGIC2:    f_class = lcd_pkg::CLS_LOGICAL;
            lcd_pkg::ST_RELOP,
            lcd_pkg::ST_RELEQ:     f_class = lcd_pkg::CLS_RELATIONAL;
            lcd_pkg::ST_SIGN,
            lcd_pkg::ST_ARITH:     f_class = lcd_pkg::CLS_ARITH;
            default:               f_class = lcd_pkg::CLS_INVALID;
        endcase
    endfunction

    lcd_pkg::t_state              r_state;
    lcd_pkg::t_state              n_state;
    logic [lcd_pkg::NUM_KW-1:0]   r_hits;
    logic [lcd_pkg::NUM_KW-1:0]   n_hits;
    logic [2:0]                   r_pos;
    logic [2:0]                   n_pos;
    logic [lcd_pkg::NUM_KW-1:0]   w_match;
    logic [lcd_pkg::NUM_KW-1:0]   w_full;
    logic                         w_kw;
    logic                         w_accept;

    assign i_char.ready = i_room;
    assign w_accept     = i_char.valid && i_room;

    // Keyword bank: compare this position of every keyword at once
    always_comb begin
        for (int k = 0; k < lcd_pkg::NUM_KW; k++) begin
            w_match[k] = ({1'b0, r_pos} < lcd_pkg::KW_LEN[k]) &&
                         (lcd_pkg::KW_TEXT[k][{r_pos, 3'b000} +: 8] == i_char.ch);
            w_full[k]  = ({1'b0, r_pos} + 4'd1) == lcd_pkg::KW_LEN[k];
        end
        n_hits = r_hits & w_match;
        w_kw   = i_char.last && |(r_hits & w_match & w_full);
    end

    assign n_state = f_next(r_state, i_char.ch);
    assign n_pos   = (r_pos == 3'd7) ? r_pos : r_pos + 3'd1;

    assign o_push.valid       = w_accept && i_char.last;
    assign o_push.token_class = f_class(n_state, w_kw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcd_pkg::ST_START;
            r_hits  <= '1;
            r_pos   <= '0;
        end else if (w_accept) begin
            // end of lexeme: restart for the next one
            if (i_char.last) begin
                r_state <= lcd_pkg::ST_START;
                r_hits  <= '1;
                r_pos   <= '0;
            end else begin
                r_state <= n_state;
                r_hits  <= n_hits;
                r_pos   <= n_pos;
            end
        end
    end

endmodule

FILE: hdl/lcd_queue.sv
// Back end: result queue between the scanner and the class output.
// Depends on lcd_pkg and lcd_class_if.
`timescale 1ns / 1ps

module lcd_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lcd_pkg::t_push    i_push,
    output logic              o_room,
    lcd_class_if.source       o_class
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    lcd_pkg::t_class   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              w_pop;

    assign w_pop  = o_class.valid && o_class.ready;
    assign o_room = r_count != CNT_W'(DEPTH);

    assign o_class.valid       = r_count != '0;
    assign o_class.token_class = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push.valid && !w_pop)      n_count = r_count + 1'b1;
        else if (!i_push.valid && w_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.token_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

endmodule
